/* rtl/mipmap_2x2_downsample_defines.svh */
// Assertion helpers for the 2x2 downsample pipeline
`ifndef MIPMAP_2X2_DOWNSAMPLE_DEFINES_SVH
`define MIPMAP_2X2_DOWNSAMPLE_DEFINES_SVH

// same-cycle implication, reset masked
`define MM2_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masked
`define MM2_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/mm2_pkg.sv */
`timescale 1ns / 1ps
package mm2_pkg;

    localparam logic CFG_DECODE_SRGB    = 1'b0;
    localparam logic CFG_ALPHA_WEIGHTED = 1'b1;

    // linear light of sRGB value n/510, Q0.lb
    function automatic logic [63:0] srgb_dec_half(input int unsigned n, input int unsigned lb);
        logic [63:0] nn;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] r2;
        logic [63:0] r4;
        logic [63:0] r5;
        logic [63:0] y;
        logic [63:0] res;
        nn = 64'(n);
        if (n <= 20) begin
            res = (((nn * 64'd100) << lb) + 64'd329460) / 64'd658920;
        end else begin
            x  = ((nn * 64'd1000 + 64'd28050) << 30) / 64'd538050;
            x2 = (x * x) >> 30;
            lo = 64'd0;
            hi = 64'd1 << 30;
            for (int i = 0; i < 32; i++) begin
                if (lo < hi) begin
                    mid = (lo + hi + 64'd1) >> 1;
                    r2  = (mid * mid) >> 30;
                    r4  = (r2 * r2) >> 30;
                    r5  = (r4 * mid) >> 30;
                    if (r5 <= x2) begin
                        lo = mid;
                    end else begin
                        hi = mid - 64'd1;
                    end
                end
            end
            y   = (x2 * lo) >> 30;
            res = (y + (64'd1 << (29 - lb))) >> (30 - lb);
        end
        return res;
    endfunction

endpackage

/* rtl/mm2_srgb_lut.sv */
`timescale 1ns / 1ps
module mm2_srgb_lut #(
    parameter int LINEAR_BITS = 16,
    parameter bit ODD         = 1'b0
) (
    input  logic [7:0]           i_idx,
    output logic [LINEAR_BITS:0] o_val
);

    logic [LINEAR_BITS:0] tbl [256];

    // even: decode of code k; odd: decode of half-code 2k-1 (encode thresholds)
    for (genvar k = 0; k < 256; k++) begin : g_ent
        localparam int unsigned NH = ODD ? ((k == 0) ? 0 : 2 * k - 1) : 2 * k;
        localparam logic [63:0] VAL = mm2_pkg::srgb_dec_half(NH, LINEAR_BITS);
        assign tbl[k] = VAL[LINEAR_BITS:0];
    end

    assign o_val = tbl[i_idx];

endmodule

/* rtl/mipmap_2x2_downsample.sv */
`timescale 1ns / 1ps
// Pipeline from input request to o_valid: 3 front stages,
// LINEAR_BITS + 1 divider stages and 8 sRGB encode stages.
// Throughput: one texel per cycle while the skid is empty; a one-entry skid holds a result the sink stalls.
// Reset (synchronous, active low) clears stage valids, the skid valid and both config bits.
module mipmap_2x2_downsample #(
    parameter int LINEAR_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic        i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_texel_top_left,
    input  logic [31:0] i_texel_top_right,
    input  logic [31:0] i_texel_bottom_left,
    input  logic [31:0] i_texel_bottom_right,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_texel_result
);

`include "mipmap_2x2_downsample_defines.svh"

    localparam int LW = LINEAR_BITS + 1;
    localparam int PW = LW + 8;
    localparam int SW = LW + 10;
    localparam int NW = LW + 11;
    localparam int QW = LW;
    localparam int NS = 3 + QW + 8;

    logic r_srgb;
    logic r_aw;

    logic          en;
    logic [NS-1:0] r_vld;

    logic        r_sk_vld;
    logic [31:0] r_sk_texel;
    logic [31:0] fin_texel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_srgb <= 1'b0;
            r_aw   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mm2_pkg::CFG_DECODE_SRGB:    r_srgb <= i_cfg_data;
                mm2_pkg::CFG_ALPHA_WEIGHTED: r_aw   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign en      = !r_sk_vld;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    // ---- stage 1: weights, alpha, decode
    logic [31:0] tx [4];
    logic [9:0]  asum;
    logic        wtd;
    logic [7:0]  cb [3][4];
    logic [LW-1:0] dec [3][4];

    assign tx[0] = i_texel_top_left;
    assign tx[1] = i_texel_top_right;
    assign tx[2] = i_texel_bottom_left;
    assign tx[3] = i_texel_bottom_right;

    assign asum = 10'(tx[0][31:24]) + 10'(tx[1][31:24]) + 10'(tx[2][31:24])
                + 10'(tx[3][31:24]);
    assign wtd  = r_aw && (asum != 10'd0);

    for (genvar c = 0; c < 3; c++) begin : g_dch
        for (genvar i = 0; i < 4; i++) begin : g_dtx
            assign cb[c][i] = tx[i][23-8*c -: 8];
            mm2_srgb_lut #(.LINEAR_BITS(LINEAR_BITS), .ODD(1'b0)) u_dec (
                .i_idx (cb[c][i]),
                .o_val (dec[c][i])
            );
        end
    end

    logic [LW-1:0] r_s1_v [3][4];
    logic [7:0]    r_s1_w [4];
    logic [9:0]    r_s1_wsum;
    logic [7:0]    r_s1_alpha;
    logic          r_s1_srgb;
    logic [10:0]   asum_rnd;

    assign asum_rnd = 11'(asum) + 11'd2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                for (int i = 0; i < 4; i++) begin
                    r_s1_v[c][i] <= r_srgb ? dec[c][i] : LW'(cb[c][i]);
                end
            end
            for (int i = 0; i < 4; i++) begin
                r_s1_w[i] <= wtd ? tx[i][31:24] : 8'd1;
            end
            r_s1_wsum  <= wtd ? asum : 10'd4;
            r_s1_alpha <= asum_rnd[9:2];
            r_s1_srgb  <= r_srgb;
        end
    end

    // ---- stage 2: weighted products
    logic [PW-1:0] r_s2_p [3][4];
    logic [9:0]    r_s2_wsum;
    logic [7:0]    r_s2_alpha;
    logic          r_s2_srgb;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                for (int i = 0; i < 4; i++) begin
                    r_s2_p[c][i] <= PW'(r_s1_v[c][i]) * PW'(r_s1_w[i]);
                end
            end
            r_s2_wsum  <= r_s1_wsum;
            r_s2_alpha <= r_s1_alpha;
            r_s2_srgb  <= r_s1_srgb;
        end
    end

    // ---- stage 3: sums, rounding numerator, divider setup
    logic [SW-1:0] psum [3];
    logic [NW-1:0] num  [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            psum[c] = SW'(r_s2_p[c][0]) + SW'(r_s2_p[c][1]) + SW'(r_s2_p[c][2])
                    + SW'(r_s2_p[c][3]);
            num[c]  = {psum[c], 1'b0} + NW'(r_s2_wsum);
        end
    end

    logic [10:0]   r_s3_rem [3];
    logic [QW-1:0] r_s3_nq  [3];
    logic [10:0]   r_s3_d;
    logic [7:0]    r_s3_alpha;
    logic          r_s3_srgb;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                r_s3_rem[c] <= num[c][NW-1:QW];
                r_s3_nq[c]  <= num[c][QW-1:0];
            end
            r_s3_d     <= {r_s2_wsum, 1'b0};
            r_s3_alpha <= r_s2_alpha;
            r_s3_srgb  <= r_s2_srgb;
        end
    end

    // ---- restoring divider, one quotient bit per stage
    logic [10:0]   r_dv_rem [QW][3];
    logic [QW-1:0] r_dv_nq  [QW][3];
    logic [10:0]   r_dv_d   [QW];
    logic [7:0]    r_dv_alpha [QW];
    logic          r_dv_srgb  [QW];

    logic [10:0]   dv_rem_in [QW][3];
    logic [QW-1:0] dv_nq_in  [QW][3];
    logic [10:0]   dv_d_in   [QW];
    logic [11:0]   dv_trial  [QW][3];
    logic          dv_ge     [QW][3];
    logic [11:0]   dv_diff   [QW][3];

    always_comb begin
        for (int j = 0; j < QW; j++) begin
            dv_d_in[j] = (j == 0) ? r_s3_d : r_dv_d[(j == 0) ? 0 : j - 1];
            for (int c = 0; c < 3; c++) begin
                dv_rem_in[j][c] = (j == 0) ? r_s3_rem[c] : r_dv_rem[(j == 0) ? 0 : j - 1][c];
                dv_nq_in[j][c]  = (j == 0) ? r_s3_nq[c]  : r_dv_nq[(j == 0) ? 0 : j - 1][c];
                dv_trial[j][c]  = {dv_rem_in[j][c], dv_nq_in[j][c][QW-1]};
                dv_ge[j][c]     = dv_trial[j][c] >= {1'b0, dv_d_in[j]};
                dv_diff[j][c]   = dv_trial[j][c] - {1'b0, dv_d_in[j]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < QW; j++) begin
                for (int c = 0; c < 3; c++) begin
                    r_dv_rem[j][c] <= dv_ge[j][c] ? dv_diff[j][c][10:0]
                                                  : dv_trial[j][c][10:0];
                    r_dv_nq[j][c]  <= {dv_nq_in[j][c][QW-2:0], dv_ge[j][c]};
                end
                r_dv_d[j] <= dv_d_in[j];
            end
            r_dv_alpha[0] <= r_s3_alpha;
            r_dv_srgb[0]  <= r_s3_srgb;
            for (int j = 1; j < QW; j++) begin
                r_dv_alpha[j] <= r_dv_alpha[j-1];
                r_dv_srgb[j]  <= r_dv_srgb[j-1];
            end
        end
    end

    // ---- sRGB encode: bit-by-bit search over the threshold table
    logic [QW-1:0] r_en_mean [8][3];
    logic [7:0]    r_en_code [8][3];
    logic [7:0]    r_en_alpha [8];
    logic          r_en_srgb  [8];

    logic [QW-1:0] en_mean_in [8][3];
    logic [7:0]    en_code_in [8][3];
    logic [7:0]    en_cand    [8][3];
    logic [LW-1:0] en_thr     [8][3];

    for (genvar b = 0; b < 8; b++) begin : g_enc
        for (genvar c = 0; c < 3; c++) begin : g_ech
            if (b == 0) begin : g_first
                assign en_mean_in[b][c] = r_dv_nq[QW-1][c];
                assign en_code_in[b][c] = 8'd0;
            end else begin : g_next
                assign en_mean_in[b][c] = r_en_mean[b-1][c];
                assign en_code_in[b][c] = r_en_code[b-1][c];
            end
            assign en_cand[b][c] = en_code_in[b][c] | (8'd1 << (7 - b));
            mm2_srgb_lut #(.LINEAR_BITS(LINEAR_BITS), .ODD(1'b1)) u_thr (
                .i_idx (en_cand[b][c]),
                .o_val (en_thr[b][c])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int b = 0; b < 8; b++) begin
                for (int c = 0; c < 3; c++) begin
                    r_en_mean[b][c] <= en_mean_in[b][c];
                    r_en_code[b][c] <= (en_thr[b][c] <= en_mean_in[b][c]) ? en_cand[b][c]
                                                                          : en_code_in[b][c];
                end
            end
            r_en_alpha[0] <= r_dv_alpha[QW-1];
            r_en_srgb[0]  <= r_dv_srgb[QW-1];
            for (int b = 1; b < 8; b++) begin
                r_en_alpha[b] <= r_en_alpha[b-1];
                r_en_srgb[b]  <= r_en_srgb[b-1];
            end
        end
    end

    // ---- final pack, skid
    logic [7:0] fin_ch [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (r_en_srgb[7]) begin
                fin_ch[c] = r_en_code[7][c];
            end else if (r_en_mean[7][c] > QW'(255)) begin
                fin_ch[c] = 8'hFF;
            end else begin
                fin_ch[c] = r_en_mean[7][c][7:0];
            end
        end
    end

    assign fin_texel = {r_en_alpha[7], fin_ch[0], fin_ch[1], fin_ch[2]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sk_vld <= 1'b0;
        end else if (r_sk_vld) begin
            if (i_ready) begin
                r_sk_vld <= 1'b0;
            end
        end else if (r_vld[NS-1] && !i_ready) begin
            r_sk_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_sk_vld && r_vld[NS-1] && !i_ready) begin
            r_sk_texel <= fin_texel;
        end
    end

    assign o_valid        = r_sk_vld || r_vld[NS-1];
    assign o_texel_result = r_sk_vld ? r_sk_texel : fin_texel;

    `MM2_ASSERT_NEXT(a_skid_holds, r_sk_vld && !i_ready, r_sk_vld && $stable(r_sk_texel), "skid request lost while stalled")
    `MM2_ASSERT_NEXT(a_stall_capture, !r_sk_vld && r_vld[NS-1] && !i_ready, r_sk_vld, "stalled result not captured")
    `MM2_ASSERT_NOW(a_frozen, r_sk_vld, !o_ready, "pipeline accepts while skid full")
    `MM2_ASSERT_NEXT(a_skid_data, !r_sk_vld && r_vld[NS-1] && !i_ready, o_texel_result == $past(fin_texel), "skid data mismatch")

endmodule
